FILE: sv/ste_pkg.sv
`default_nettype none
package ste_pkg;

  localparam int unsigned CharW      = 7;
  localparam int unsigned SymW       = 6;
  localparam int unsigned MaxChars   = 4;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CharW-1:0] OPEN_CHAR  = 7'h23;
  localparam logic [CharW-1:0] CLOSE_CHAR = 7'h21;
  localparam logic [CharW-1:0] SYM_OFFSET = 7'h3C;

  // One classified byte: the characters it produces, the index of the final
  // character, and whether that final character closes the message.
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [$clog2(MaxChars)-1:0]    last_idx;
    logic                           closes;
  } ste_entry_t;

endpackage
`default_nettype wire

FILE: sv/ste_in_if.sv
`default_nettype none
interface ste_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface
`default_nettype wire

FILE: sv/ste_out_if.sv
`default_nettype none
interface ste_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       frame_end;

  modport source (output valid, output out_char, output frame_end, input ready);
  modport sink (input valid, input out_char, input frame_end, output ready);
endinterface
`default_nettype wire

FILE: sv/ste_front.sv
`default_nettype none
module ste_front
  import ste_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ste_in_if.sink      in_i,
  input  wire logic   full_i,
  output logic        push_o,
  output ste_entry_t  entry_o
);

  logic [1:0]      phase_q, phase_d;
  logic [SymW-1:0] leftover_q, leftover_d;
  logic            in_msg_q, in_msg_d;

  logic [SymW-1:0] made;
  logic [SymW-1:0] rest;
  logic [2:0]      n;
  logic [7:0]      b;

  function automatic logic [CharW-1:0] to_char(input logic [SymW-1:0] s);
    return {1'b0, s} + SYM_OFFSET;
  endfunction

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign b          = in_i.data_byte;

  always_comb begin
    // The phase counts pending bits in pairs; an out-of-range phase acts as two pairs.
    case (phase_q)
      2'd0: begin
        made = b[7:2];
        rest = {b[1:0], 4'b0000};
      end
      2'd1: begin
        made = leftover_q | {2'b00, b[7:4]};
        rest = {b[3:0], 2'b00};
      end
      default: begin
        made = leftover_q | {4'b0000, b[7:6]};
        rest = b[5:0];
      end
    endcase

    entry_o.chars = '0;
    n             = 3'd0;
    in_msg_d      = 1'b1;

    if (!in_msg_q) begin
      entry_o.chars[0] = OPEN_CHAR;
      n                = 3'd1;
    end
    entry_o.chars[n[1:0]] = to_char(made);
    n = n + 3'd1;

    if (phase_q == 2'd2 || phase_q == 2'd3) begin
      entry_o.chars[n[1:0]] = to_char(rest);
      n          = n + 3'd1;
      phase_d    = 2'd0;
      leftover_d = '0;
    end else begin
      phase_d    = phase_q + 2'd1;
      leftover_d = rest;
    end

    entry_o.closes = in_i.end_of_message;
    if (in_i.end_of_message) begin
      if (phase_d != 2'd0) begin
        entry_o.chars[n[1:0]] = to_char(leftover_d);
        n = n + 3'd1;
      end
      entry_o.chars[n[1:0]] = CLOSE_CHAR;
      n          = n + 3'd1;
      phase_d    = 2'd0;
      leftover_d = '0;
      in_msg_d   = 1'b0;
    end

    entry_o.last_idx = 2'(n - 3'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 2'd0;
      leftover_q <= '0;
      in_msg_q   <= 1'b0;
    end else if (push_o) begin
      phase_q    <= phase_d;
      leftover_q <= leftover_d;
      in_msg_q   <= in_msg_d;
    end
  end

endmodule
`default_nettype wire

FILE: sv/ste_fifo.sv
`default_nettype none
module ste_fifo
  import ste_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire ste_entry_t  entry_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output ste_entry_t       entry_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  ste_entry_t      mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/ste_back.sv
`default_nettype none
module ste_back
  import ste_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ste_entry_t  entry_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  ste_out_if.source        out_o
);

  localparam int unsigned IdxW = $clog2(MaxChars);

  logic [IdxW-1:0]             idx_q;
  logic                        valid_q;
  logic [CharW-1:0]            char_q;
  logic                        frame_end_q;
  logic                        load;
  logic                        take;
  logic                        at_last;

  assign load    = !valid_q || out_o.ready;
  assign take    = load && !empty_i;
  assign at_last = (idx_q == entry_i.last_idx);
  assign pop_o   = take && at_last;

  assign out_o.valid     = valid_q;
  assign out_o.out_char  = char_q;
  assign out_o.frame_end = frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= !empty_i;
      end
      if (take) begin
        idx_q <= at_last ? '0 : idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      char_q      <= entry_i.chars[idx_q];
      frame_end_q <= entry_i.closes && at_last;
    end
  end

endmodule
`default_nettype wire

FILE: sv/sixbit_text_encoder_top.sv
// Six-bit printable text encoder.
// in_i carries one message byte per item with an end_of_message flag on the
// final byte. out_o carries one character per item: '#' before the first
// symbol of a message, then each 6-bit symbol plus 0x3C, most significant
// bits first, and after the final byte the flushed partial symbol, if any,
// and a closing '!' marked by frame_end.
// The front stage classifies a byte in the cycle it is accepted and writes
// its one to four characters into a two-entry queue; the back stage sends
// one character per cycle from an output register while out_o is ready.
// A byte's first character is written to the queue, then to that register.
// Throughput is set by the single output register: one character per cycle
// while the receiver is ready; a byte yields one to four characters, about 1.33
// over a long message. in_i stays ready while the queue has a free entry.
// When the receiver stalls, the output holds and the queue fills; after two
// bytes are waiting, in_i drops ready until an entry drains.
// Reset empties the queue and the output register and closes any open
// message, so the next byte starts a new one with '#'.
`default_nettype none
module sixbit_text_encoder_top
  import ste_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ste_in_if.sink     in_i,
  ste_out_if.source  out_o
);

  ste_entry_t front_entry;
  ste_entry_t head_entry;
  logic       push;
  logic       full;
  logic       pop;
  logic       empty;

  ste_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (front_entry)
  );

  ste_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty)
  );

  ste_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire

FILE: dv/tb_sixbit_text_encoder_top.sv
`timescale 1ns / 1ps
module tb_sixbit_text_encoder_top;
  import ste_pkg::*;

  localparam int unsigned StallPct   = 20;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned TargetBytes = 310;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             frame_end;
  } enc_char_t;

  logic clk_i;
  logic rst_ni;

  ste_in_if  byte_bus ();
  ste_out_if char_bus ();

  sixbit_text_encoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_bus.sink),
    .out_o  (char_bus.source)
  );

  // Encoder state as seen by the predictor.
  logic [1:0]      enc_phase    = '0;
  logic [SymW-1:0] enc_leftover = '0;
  logic            enc_open     = 1'b0;

  enc_char_t   expected_chars[$];
  int unsigned mismatches    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned messages_sent = 0;
  int unsigned chars_checked = 0;
  int unsigned idle_cycles   = 0;
  bit          steady        = 1'b0;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic void push_char(input logic [CharW-1:0] ch, input logic fe);
    enc_char_t c;
    c.out_char  = ch;
    c.frame_end = fe;
    expected_chars.insert(expected_chars.size(), c);
  endfunction

  // Works out the characters that one accepted byte produces.
  function automatic void encode_byte(input logic [7:0] b, input logic eom);
    logic [1:0]      phase;
    logic [2:0]      pend_bits;
    logic [7:0]      shifted;
    logic [SymW-1:0] sym;
    logic [SymW-1:0] rest;
    phase = (enc_phase > 2'd2) ? 2'd2 : enc_phase;
    pend_bits = {phase, 1'b0};
    if (!enc_open) begin
      push_char(OPEN_CHAR, 1'b0);
      enc_open = 1'b1;
    end
    shifted = b >> (3'd2 + pend_bits);
    sym = enc_leftover | shifted[SymW-1:0];
    shifted = b << (3'd4 - pend_bits);
    rest = shifted[SymW-1:0];
    push_char({1'b0, sym} + SYM_OFFSET, 1'b0);
    if (phase == 2'd2) begin
      push_char({1'b0, rest} + SYM_OFFSET, 1'b0);
      enc_phase = 2'd0;
      enc_leftover = '0;
    end else begin
      enc_phase = phase + 2'd1;
      enc_leftover = rest;
    end
    if (eom) begin
      if (enc_phase != 2'd0) push_char({1'b0, enc_leftover} + SYM_OFFSET, 1'b0);
      push_char(CLOSE_CHAR, 1'b1);
      enc_phase = 2'd0;
      enc_leftover = '0;
      enc_open = 1'b0;
    end
  endfunction

  always @(negedge clk_i) begin
    char_bus.ready <= steady ? 1'b1 : ($urandom_range(99) >= StallPct);
  end

  // Results are checked before the byte of the same edge is predicted; a byte
  // never produces a character at the edge where it is accepted.
  always @(posedge clk_i) begin
    enc_char_t exp_c;
    bit        moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (char_bus.valid === 1'b1 && char_bus.ready === 1'b1) begin
        moved = 1'b1;
        if (expected_chars.size() == 0) begin
          $error("unexpected character: out_char 0x%02h frame_end %0b",
                 char_bus.out_char, char_bus.frame_end);
          mismatches++;
        end else begin
          exp_c = expected_chars.pop_front();
          chars_checked++;
          if (char_bus.out_char !== exp_c.out_char) begin
            $error("out_char: expected 0x%02h, actual 0x%02h",
                   exp_c.out_char, char_bus.out_char);
            mismatches++;
          end
          if (char_bus.frame_end !== exp_c.frame_end) begin
            $error("frame_end: expected %0b, actual %0b",
                   exp_c.frame_end, char_bus.frame_end);
            mismatches++;
          end
        end
      end
      if (byte_bus.valid === 1'b1 && byte_bus.ready === 1'b1) begin
        moved = 1'b1;
        encode_byte(byte_bus.data_byte, byte_bus.end_of_message);
      end
    end
    if (moved || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no item moved for %0d cycles", IdleLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eom);
    @(negedge clk_i);
    if (!steady) begin
      while ($urandom_range(99) < StallPct) begin
        byte_bus.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    byte_bus.valid          <= 1'b1;
    byte_bus.data_byte      <= b;
    byte_bus.end_of_message <= eom;
    @(posedge clk_i);
    while (byte_bus.ready !== 1'b1) @(posedge clk_i);
    bytes_sent++;
    if (eom) messages_sent++;
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  // Lengths one to four cover every bit phase at the close, with and without
  // a partial symbol to flush; all-zero and all-one bytes give the extreme
  // characters.
  task automatic test_short_messages();
    send_message('{8'h00});
    send_message('{8'hFF});
    send_message('{8'hAA, 8'h55});
    send_message('{8'hFF, 8'h00, 8'hFF});
    send_message('{8'h12, 8'h34, 8'h56, 8'h78});
  endtask

  // A walking one crosses every bit position of the symbol grouping.
  task automatic test_walking_bits();
    send_message('{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hFE});
  endtask

  task automatic test_random_messages();
    logic [7:0]  msg[$];
    int unsigned len;
    int unsigned steady_until;
    steady_until = bytes_sent + 100;
    steady = 1'b1;
    while (bytes_sent < TargetBytes) begin
      if (bytes_sent >= steady_until) steady = 1'b0;
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 11) : $urandom_range(10, 1);
      msg.delete();
      repeat (len) msg.insert(msg.size(), 8'($urandom_range(255)));
      send_message(msg);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni                  = 1'b0;
    byte_bus.valid          = 1'b0;
    byte_bus.data_byte      = '0;
    byte_bus.end_of_message = 1'b0;
    char_bus.ready          = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_short_messages();
    test_walking_bits();
    test_random_messages();

    @(negedge clk_i);
    byte_bus.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Encoded %0d bytes in %0d messages of 1 to 30 bytes;", bytes_sent,
             messages_sent);
    $display("%0d characters checked under random stalls on both sides.", chars_checked);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sixbit_text_encoder_top.f
sv/ste_pkg.sv
sv/ste_in_if.sv
sv/ste_out_if.sv
sv/ste_front.sv
sv/ste_fifo.sv
sv/ste_back.sv
sv/sixbit_text_encoder_top.sv
dv/tb_sixbit_text_encoder_top.sv
